/* rtl/lmts_pkg.sv */
// Package for the LED matrix text scroller: item structs, state and register codes.
// Used by led_matrix_text_scroller; depends on nothing else.
package lmts_pkg;

    typedef struct packed {
        logic        kind;
        logic [3:0]  row;
        logic [10:0] glyph_addr;
        logic [7:0]  glyph_byte;
    } cmd_t;

    typedef struct packed {
        logic [3:0] row_select;
        logic       pixel_bit;
        logic       last;
    } pix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHIFT
    } state_t;

    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_SCAN  = 1'b1;

    localparam logic [2:0] MODE_STATIC = 3'd0;
    localparam logic [2:0] MODE_LEFT   = 3'd1;
    localparam logic [2:0] MODE_RIGHT  = 3'd2;
    localparam logic [2:0] MODE_UP     = 3'd3;
    localparam logic [2:0] MODE_DOWN   = 3'd4;

    localparam logic [1:0] REG_SCROLL_MODE     = 2'd0;
    localparam logic [1:0] REG_FRAMES_PER_STEP = 2'd1;
    localparam logic [1:0] REG_MESSAGE_GLYPHS  = 2'd2;

    localparam logic [7:0] FRAMES_PER_STEP_RESET = 8'd100;
    localparam logic [5:0] MESSAGE_GLYPHS_RESET  = 6'd1;
    localparam logic [4:0] GLYPH_COLS            = 5'd16;

endpackage

/* rtl/led_matrix_text_scroller.sv */
// Scrolling text engine for a 16-row LED matrix fed by a serial shift chain.
// Glyph memory, scan sequencer and scroll stepping; depends on lmts_pkg.
//
//   channel   direction  handshake              payload
//   cmd       in         cmd_valid / cmd_stall  cmd_data  (cmd_t)
//   pix       out        pix_valid / pix_stall  pix_data  (pix_t)
//   config    in         APB write, read back   scroll_mode, frames_per_step, message_glyphs
//
// A glyph write item is stored in the cycle it is accepted. A scan item reads the memory
// for its three glyph row words, then shifts out its output bits (32 to 47), with an
// extra step at each of the one or two segment changes.
// The memory needs no clearing pass after reset; scroll state resets to zero.
// While pix_stall is high and a bit is waiting the shifter holds; cmd items are taken only when idle.
module led_matrix_text_scroller
    import lmts_pkg::*;
#(
    parameter int GLYPH_SLOTS = 64,
    parameter int GLYPH_ROWS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_t        cmd_data,
    output logic        pix_valid,
    input  logic        pix_stall,
    output pix_t        pix_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORDS       = GLYPH_SLOTS * GLYPH_ROWS;
    localparam int STORE_BYTES = 2 * WORDS;
    localparam int WA_W        = $clog2(WORDS);
    localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
    localparam int ROW_W       = $clog2(GLYPH_ROWS);

    function automatic logic [ROW_W-1:0] mod_rows(input logic [5:0] v);
        logic [5:0] r;
        if (v >= 6'(2 * GLYPH_ROWS))
        begin
            r = v - 6'(2 * GLYPH_ROWS);
        end
        else if (v >= 6'(GLYPH_ROWS))
        begin
            r = v - 6'(GLYPH_ROWS);
        end
        else
        begin
            r = v;
        end
        return ROW_W'(r);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_mod(input logic signed [7:0] s);
        logic [12:0] x;
        x = (s < 0) ? 13'(s) + 13'(GLYPH_SLOTS) : 13'(s);
        for (int j = 4; j >= 0; j--)
        begin
            if (x >= 13'(GLYPH_SLOTS << j))
            begin
                x = x - 13'(GLYPH_SLOTS << j);
            end
        end
        return SLOT_W'(x);
    endfunction

    state_t state_reg, state_next;

    logic [2:0] mode_reg, mode_next;
    logic [7:0] fps_reg, fps_next;
    logic [5:0] mg_reg, mg_next;

    logic [3:0] off_reg, off_next;
    logic [5:0] gidx_reg, gidx_next;
    logic [7:0] frame_reg, frame_next;

    logic [1:0] fetch_reg, fetch_next;
    logic       rd_valid_reg, rd_valid_next;
    logic [1:0] rd_k_reg, rd_k_next;
    logic [1:0] seg_reg, seg_next;
    logic [4:0] col_reg, col_next;
    logic       pix_valid_reg, pix_valid_next;

    logic [3:0]              row_reg;
    logic [ROW_W-1:0]        wrow_reg;
    logic signed [7:0]       base_reg;
    logic [4:0]              first_reg [3];
    logic [4:0]              stop_reg [3];
    logic [15:0]             rdata_reg;
    logic [15:0]             word_reg [3];
    pix_t                    pix_reg;

    logic [15:0] glyph_mem [WORDS];

    logic              cmd_acc;
    logic              scan_acc;
    logic              wr_en;
    logic [WA_W-1:0]   wr_addr;
    logic              rd_en;
    logic [WA_W-1:0]   rd_addr;
    logic signed [7:0] fetch_slot;
    logic              cfg_wr;
    logic              step_en;

    logic [ROW_W-1:0]  plan_wrow;
    logic signed [7:0] plan_base;
    logic [4:0]        plan_first [3];
    logic [4:0]        plan_stop [3];

    logic [3:0] adv_off;
    logic [5:0] adv_gidx;
    logic [7:0] adv_frame;

    logic [1:0] seg_inc;
    logic       seg_done;
    logic       later_ne;
    logic       bit_last;
    logic       pix_free;
    logic       pix_load;
    pix_t       pix_next;

    assign pready    = 1'b1;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign scan_acc  = cmd_acc && (cmd_data.kind == KIND_SCAN);
    assign wr_en     = cmd_acc && (cmd_data.kind == KIND_WRITE)
                       && ({3'b000, cmd_data.glyph_addr} < 14'(STORE_BYTES));
    assign wr_addr   = WA_W'(cmd_data.glyph_addr[10:1]);
    assign rd_en     = (state_reg == ST_FETCH);
    assign fetch_slot = base_reg + $signed({6'b000000, fetch_reg});
    assign rd_addr   = WA_W'(slot_mod(fetch_slot)) * WA_W'(GLYPH_ROWS) + WA_W'(wrow_reg);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_reg;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCROLL_MODE:     prdata = {29'd0, mode_reg};
            REG_FRAMES_PER_STEP: prdata = {24'd0, fps_reg};
            REG_MESSAGE_GLYPHS:  prdata = {26'd0, mg_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        logic [ROW_W-1:0]  grow;
        logic [5:0]        t_up;
        logic [5:0]        t_dn;
        logic signed [7:0] idx_s;
        grow  = mod_rows({2'b00, cmd_data.row});
        t_up  = 6'(grow) + 6'(off_reg);
        t_dn  = 6'(grow) + 6'(2 * GLYPH_ROWS) - 6'(off_reg);
        idx_s = $signed({2'b00, gidx_reg});
        plan_wrow     = grow;
        plan_base     = idx_s;
        plan_first[0] = 5'd0;
        plan_first[1] = 5'd0;
        plan_first[2] = 5'd0;
        plan_stop[0]  = GLYPH_COLS;
        plan_stop[1]  = GLYPH_COLS;
        plan_stop[2]  = 5'(off_reg);
        case (mode_reg)
            MODE_RIGHT:
            begin
                plan_first[0] = GLYPH_COLS - 5'(off_reg);
                plan_stop[2]  = GLYPH_COLS - 5'(off_reg);
            end
            MODE_UP:
            begin
                plan_wrow    = mod_rows(t_up);
                plan_stop[2] = 5'd0;
                if (t_up >= 6'(GLYPH_ROWS))
                begin
                    plan_base = idx_s + 8'sd2;
                end
            end
            MODE_DOWN:
            begin
                plan_wrow    = mod_rows(t_dn);
                plan_stop[2] = 5'd0;
                if (6'(grow) < 6'(off_reg))
                begin
                    plan_base = idx_s - 8'sd2;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        logic [7:0] frame_inc;
        logic [3:0] off_inc;
        logic [5:0] g_up1;
        logic [6:0] g_up2;
        logic [5:0] g_dn2;
        frame_inc = frame_reg + 8'd1;
        off_inc   = off_reg + 4'd1;
        g_up1     = gidx_reg + 6'd1;
        g_up2     = 7'(gidx_reg) + 7'd2;
        g_dn2     = gidx_reg - 6'd2;
        case (mode_reg) inside
            MODE_LEFT, MODE_RIGHT, MODE_UP, MODE_DOWN: step_en = 1'b1;
            default:                                   step_en = 1'b0;
        endcase
        adv_frame = frame_reg;
        adv_off   = off_reg;
        adv_gidx  = gidx_reg;
        if (step_en)
        begin
            adv_frame = frame_inc;
            if (frame_inc == fps_reg)
            begin
                adv_frame = 8'd0;
                adv_off   = off_inc;
                if (off_inc == 4'd0)
                begin
                    case (mode_reg)
                        MODE_LEFT:
                            adv_gidx = (7'(g_up1) == 7'(mg_reg) + 7'd2) ? 6'd0 : g_up1;
                        MODE_RIGHT:
                            adv_gidx = (gidx_reg == 6'd0) ? mg_reg + 6'd1 : gidx_reg - 6'd1;
                        MODE_UP:
                            adv_gidx = (g_up2 >= 7'(mg_reg)) ? 6'd0 : 6'(g_up2);
                        default:
                            adv_gidx = (g_dn2 <= 6'd2) ? mg_reg + 6'd2 : g_dn2;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        seg_inc  = seg_reg + 2'd1;
        seg_done = (col_reg == stop_reg[seg_reg]);
        case (seg_reg)
            2'd0:    later_ne = (first_reg[1] != stop_reg[1]) || (first_reg[2] != stop_reg[2]);
            2'd1:    later_ne = (first_reg[2] != stop_reg[2]);
            default: later_ne = 1'b0;
        endcase
        bit_last = (col_reg + 5'd1 == stop_reg[seg_reg]) && !later_ne;
        pix_free = !pix_valid_reg || !pix_stall;
        pix_load = (state_reg == ST_SHIFT) && !seg_done && pix_free;

        pix_next.row_select = row_reg;
        pix_next.pixel_bit  = ~word_reg[seg_reg][~col_reg[3:0]];
        pix_next.last       = bit_last;

        state_next     = state_reg;
        mode_next      = mode_reg;
        fps_next       = fps_reg;
        mg_next        = mg_reg;
        off_next       = off_reg;
        gidx_next      = gidx_reg;
        frame_next     = frame_reg;
        fetch_next     = fetch_reg;
        seg_next       = seg_reg;
        col_next       = col_reg;
        rd_valid_next  = (state_reg == ST_FETCH);
        rd_k_next      = fetch_reg;
        pix_valid_next = pix_valid_reg && pix_stall;

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SCROLL_MODE:     mode_next = pwdata[2:0];
                REG_FRAMES_PER_STEP: fps_next  = pwdata[7:0];
                REG_MESSAGE_GLYPHS:  mg_next   = pwdata[5:0];
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (scan_acc)
                begin
                    state_next = ST_FETCH;
                    fetch_next = 2'd0;
                    seg_next   = 2'd0;
                    col_next   = plan_first[0];
                    off_next   = adv_off;
                    gidx_next  = adv_gidx;
                    frame_next = adv_frame;
                end
            end
            ST_FETCH:
            begin
                fetch_next = fetch_reg + 2'd1;
                if (fetch_reg == 2'd2)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (seg_done)
                begin
                    if (seg_reg != 2'd2)
                    begin
                        seg_next = seg_inc;
                        col_next = first_reg[seg_inc];
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (pix_free)
                begin
                    pix_valid_next = 1'b1;
                    col_next       = col_reg + 5'd1;
                    if (bit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_STATIC;
            fps_reg       <= FRAMES_PER_STEP_RESET;
            mg_reg        <= MESSAGE_GLYPHS_RESET;
            off_reg       <= 4'd0;
            gidx_reg      <= 6'd0;
            frame_reg     <= 8'd0;
            fetch_reg     <= 2'd0;
            rd_valid_reg  <= 1'b0;
            rd_k_reg      <= 2'd0;
            seg_reg       <= 2'd0;
            col_reg       <= 5'd0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            fps_reg       <= fps_next;
            mg_reg        <= mg_next;
            off_reg       <= off_next;
            gidx_reg      <= gidx_next;
            frame_reg     <= frame_next;
            fetch_reg     <= fetch_next;
            rd_valid_reg  <= rd_valid_next;
            rd_k_reg      <= rd_k_next;
            seg_reg       <= seg_next;
            col_reg       <= col_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            row_reg  <= cmd_data.row;
            wrow_reg <= plan_wrow;
            base_reg <= plan_base;
            for (int k = 0; k < 3; k++)
            begin
                first_reg[k] <= plan_first[k];
                stop_reg[k]  <= plan_stop[k];
            end
        end
        if (rd_valid_reg)
        begin
            word_reg[rd_k_reg] <= rdata_reg;
        end
        if (pix_load)
        begin
            pix_reg <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (cmd_data.glyph_addr[0])
            begin
                glyph_mem[wr_addr][7:0] <= cmd_data.glyph_byte;
            end
            else
            begin
                glyph_mem[wr_addr][15:8] <= cmd_data.glyph_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= glyph_mem[rd_addr];
        end
    end

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("Glyph memory written and read in the same cycle.");

    a_scan_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        scan_acc |=> (state_reg == ST_FETCH) && (fetch_reg == 2'd0))
        else $error("Accepted scan item did not start the word fetch.");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_load && pix_next.last) |=> (state_reg == ST_IDLE))
        else $error("Sequencer did not return to idle after the final bit.");

    a_word_copy: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_FETCH) && (rd_k_reg != 2'd3))
        else $error("Read data arrived without a fetch cycle before it.");

endmodule
